/* src/mte_pkg.sv */
// shared types, constants and edge tables for the tetrahedra vertex extractor
// no dependencies
package mte_pkg;

  localparam int GRID_SIDE = 256;
  localparam int NUM_EDGES = 36;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int LIM_RAW = (GRID_SIDE - 1) * 256;
  localparam logic [15:0] COORD_LIM = (LIM_RAW > 65535) ? 16'hFFFF : 16'(LIM_RAW);
  localparam logic [7:0] ISO_RESET = 8'd25;

  // first and second corner of every edge, tetrahedron-major, edge order AB AC AD BC BD CD
  localparam logic [2:0] EDGE_A [NUM_EDGES] = '{
    3'd0, 3'd0, 3'd0, 3'd3, 3'd3, 3'd5,
    3'd0, 3'd0, 3'd0, 3'd7, 3'd7, 3'd3,
    3'd0, 3'd0, 3'd0, 3'd7, 3'd7, 3'd3,
    3'd0, 3'd0, 3'd0, 3'd6, 3'd6, 3'd5,
    3'd0, 3'd0, 3'd0, 3'd7, 3'd7, 3'd6,
    3'd0, 3'd0, 3'd0, 3'd7, 3'd7, 3'd6
  };
  localparam logic [2:0] EDGE_B [NUM_EDGES] = '{
    3'd3, 3'd5, 3'd1, 3'd5, 3'd1, 3'd1,
    3'd7, 3'd3, 3'd2, 3'd3, 3'd2, 3'd2,
    3'd7, 3'd3, 3'd5, 3'd3, 3'd5, 3'd5,
    3'd6, 3'd5, 3'd4, 3'd5, 3'd4, 3'd4,
    3'd7, 3'd6, 3'd2, 3'd6, 3'd2, 3'd2,
    3'd7, 3'd6, 3'd5, 3'd6, 3'd5, 3'd5
  };

  typedef struct packed {
    logic [7:0][7:0]       corner;
    logic [2:0][7:0]       org;
    logic [7:0]            thr;
    logic [NUM_EDGES-1:0]  mask;
  } cube_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* src/mte_front.sv */
// front end: classifies corners against the threshold and marks crossing edges
// depends on mte_pkg
module mte_front (
  input  logic [7:0][7:0]         corner,
  input  logic [2:0][7:0]         org,
  input  logic [7:0]              thr,
  output mte_pkg::cube_entry_t    entry,
  output logic                    has_cross
);
  import mte_pkg::*;

  logic [7:0]           below;
  logic [NUM_EDGES-1:0] mask;

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      below[c] = corner[c] < thr;
    end
    for (int k = 0; k < NUM_EDGES; k++) begin
      mask[k] = below[EDGE_A[k]] ^ below[EDGE_B[k]];
    end
  end

  assign entry.corner = corner;
  assign entry.org    = org;
  assign entry.thr    = thr;
  assign entry.mask   = mask;
  assign has_cross    = |mask;

endmodule

/* src/mte_queue.sv */
// small register queue between the front and back ends
// depends on mte_pkg
module mte_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  mte_pkg::cube_entry_t    wr_data,
  input  logic                    pop,
  output mte_pkg::cube_entry_t    rd_data,
  output mte_pkg::q_status_t      status
);
  import mte_pkg::*;

  cube_entry_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]     count_r, count_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  assign rd_data      = mem_r[rd_ptr_r];
  assign status.full  = count_r == (Q_PTR_W+1)'(Q_DEPTH);
  assign status.empty = count_r == '0;

endmodule

/* src/mte_back.sv */
// back end: walks crossing edges, divides for the fraction, places each vertex
// depends on mte_pkg
module mte_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mte_pkg::cube_entry_t    q_data,
  input  mte_pkg::q_status_t      q_status,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [15:0]             vert_x,
  output logic [15:0]             vert_y,
  output logic [15:0]             vert_z,
  output logic                    last_vertex
);
  import mte_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SEL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  cube_entry_t          cur_r;
  logic [NUM_EDGES-1:0] mask_r, mask_nxt;
  logic [2:0]           lo_r, hi_r;
  logic [7:0]           den_r, rem_r, rem_nxt;
  logic [7:0]           q_r, q_nxt;
  logic                 q8_r;
  logic                 half_r;
  logic                 out_valid_r;
  logic [15:0]          vx_r, vy_r, vz_r;
  logic                 last_r;

  // edge select
  logic [$clog2(NUM_EDGES)-1:0] idx;
  logic [2:0] ca, cb;
  logic [7:0] va, vb;
  always_comb begin
    idx = '0;
    for (int k = NUM_EDGES - 1; k >= 0; k--) begin
      if (mask_r[k]) idx = ($clog2(NUM_EDGES))'(k);
    end
    ca = EDGE_A[idx];
    cb = EDGE_B[idx];
    va = cur_r.corner[ca];
    vb = cur_r.corner[cb];
  end

  // four restoring steps per cycle
  always_comb begin
    logic [8:0] r9;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    for (int s = 0; s < 4; s++) begin
      r9 = {rem_nxt, 1'b0};
      if (r9 >= {1'b0, den_r}) begin
        rem_nxt = 8'(r9 - {1'b0, den_r});
        q_nxt   = {q_nxt[6:0], 1'b1};
      end else begin
        rem_nxt = r9[7:0];
        q_nxt   = {q_nxt[6:0], 1'b0};
      end
    end
  end

  // vertex placement
  logic [8:0]  frac;
  logic [15:0] pos [3];
  always_comb begin
    logic [17:0] base, v;
    frac = {q8_r, q_r};
    for (int ax = 0; ax < 3; ax++) begin
      base = (18'(cur_r.org[ax]) + 18'(lo_r[ax])) << 8;
      if (hi_r[ax] && !lo_r[ax])      v = base + 18'(frac);
      else if (!hi_r[ax] && lo_r[ax]) v = base - 18'(frac);
      else                            v = base;
      pos[ax] = (v > 18'(COORD_LIM)) ? COORD_LIM : v[15:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == S_IDLE) && !q_status.empty;

  always_comb begin
    state_nxt = state_r;
    mask_nxt  = mask_r;
    unique case (state_r)
      S_IDLE: if (!q_status.empty) begin
        state_nxt = S_SEL;
        mask_nxt  = q_data.mask;
      end
      S_SEL: begin
        state_nxt     = S_DIV;
        mask_nxt[idx] = 1'b0;
      end
      S_DIV: if (half_r) state_nxt = S_OUT;
      S_OUT: if (out_free) state_nxt = (mask_r == '0) ? S_IDLE : S_SEL;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SEL) half_r <= 1'b0;
      else if (state_r == S_DIV) half_r <= !half_r;
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    if (q_pop) cur_r <= q_data;
    if (state_r == S_SEL) begin
      // the lower-valued end is the one below the threshold
      if (va > vb) begin
        lo_r  <= cb;
        hi_r  <= ca;
        den_r <= va - vb;
        q8_r  <= (cur_r.thr - vb) == (va - vb);
        rem_r <= ((cur_r.thr - vb) == (va - vb)) ? 8'd0 : cur_r.thr - vb;
      end else begin
        lo_r  <= ca;
        hi_r  <= cb;
        den_r <= vb - va;
        q8_r  <= (cur_r.thr - va) == (vb - va);
        rem_r <= ((cur_r.thr - va) == (vb - va)) ? 8'd0 : cur_r.thr - va;
      end
      q_r <= '0;
    end else if (state_r == S_DIV) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
    if (state_r == S_OUT && out_free) begin
      vx_r   <= pos[0];
      vy_r   <= pos[1];
      vz_r   <= pos[2];
      last_r <= mask_r == '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign vert_x      = vx_r;
  assign vert_y      = vy_r;
  assign vert_z      = vz_r;
  assign last_vertex = last_r;

endmodule

/* src/marching_tetrahedra_vertex_extract.sv */
// marching tetrahedra vertex extractor: cube in, crossing vertices out
// a crossing cube goes through the queue, then idle, select, divide, output
// throughput: one cube per cycle while the queue has room; cubes with no
//   crossing are dropped at the front; in the back end each vertex goes through
//   edge select, divide (four quotient bits at a time) and placement
// reset: synchronous active-low rst_n empties the queue, threshold returns to 25
module marching_tetrahedra_vertex_extract (
  input  logic        clk,
  input  logic        rst_n,
  // cube input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_corner0,
  input  logic [7:0]  in_corner1,
  input  logic [7:0]  in_corner2,
  input  logic [7:0]  in_corner3,
  input  logic [7:0]  in_corner4,
  input  logic [7:0]  in_corner5,
  input  logic [7:0]  in_corner6,
  input  logic [7:0]  in_corner7,
  input  logic [7:0]  in_cube_x,
  input  logic [7:0]  in_cube_y,
  input  logic [7:0]  in_cube_z,
  // vertex output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_vert_x,
  output logic [15:0] out_vert_y,
  output logic [15:0] out_vert_z,
  output logic        out_last_vertex,
  // threshold write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_iso_threshold
);
  import mte_pkg::*;

  logic [7:0]  iso_r;
  cube_entry_t fr_entry, q_data;
  q_status_t   q_status;
  logic        has_cross, push, pop, in_take;

  // threshold register, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_r <= ISO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      iso_r <= cfg_iso_threshold;
    end
  end

  // front end: classify corners, mark crossing edges
  mte_front u_front (
    .corner    ({in_corner7, in_corner6, in_corner5, in_corner4,
                 in_corner3, in_corner2, in_corner1, in_corner0}),
    .org       ({in_cube_z, in_cube_y, in_cube_x}),
    .thr       (iso_r),
    .entry     (fr_entry),
    .has_cross (has_cross)
  );

  // only cubes with at least one crossing enter the queue
  assign in_stall = q_status.full;
  assign in_take  = in_valid && !in_stall;
  assign push     = in_take && has_cross;

  mte_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (fr_entry),
    .pop     (pop),
    .rd_data (q_data),
    .status  (q_status)
  );

  // back end: one vertex per transaction on the output channel
  mte_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_data      (q_data),
    .q_status    (q_status),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .vert_x      (out_vert_x),
    .vert_y      (out_vert_y),
    .vert_z      (out_vert_z),
    .last_vertex (out_last_vertex)
  );

`ifndef SYNTH
  // queue cannot report full and empty together
  a_q_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty at once");

  // back end never pops an empty queue
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // front end never pushes into a full queue
  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("push into full queue");
`endif

endmodule

/* tb/tb_marching_tetrahedra_vertex_extract.sv */
// testbench for the marching tetrahedra vertex extractor: directed and random cubes
// predicts every crossing vertex in a local model and checks the output stream
// depends on src/mte_pkg.sv and src/marching_tetrahedra_vertex_extract.sv
`timescale 1ns / 1ps

module tb_marching_tetrahedra_vertex_extract;
  import mte_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        last;
  } vertex_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;

  // tetrahedron corner table, corners a b c d
  localparam logic [2:0] TET [6][4] = '{
    '{3'd0, 3'd3, 3'd5, 3'd1}, '{3'd0, 3'd7, 3'd3, 3'd2}, '{3'd0, 3'd7, 3'd3, 3'd5},
    '{3'd0, 3'd6, 3'd5, 3'd4}, '{3'd0, 3'd7, 3'd6, 3'd2}, '{3'd0, 3'd7, 3'd6, 3'd5}
  };
  localparam int EA [6] = '{0, 0, 0, 1, 1, 2};
  localparam int EB [6] = '{1, 2, 3, 2, 3, 3};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_corner [8];
  logic [7:0] in_cube_x = '0, in_cube_y = '0, in_cube_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_vert_x, out_vert_y, out_vert_z;
  logic out_last_vertex;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_iso_threshold = '0;

  logic [7:0] iso_model = ISO_RESET;
  vertex_t pending_vertices [$];
  int unsigned failures = 0;
  int unsigned idle_cycles = 0;
  bit stall_always_off = 1'b0;

  initial for (int i = 0; i < 8; i++) in_corner[i] = '0;

  always #10 clk = ~clk;

  marching_tetrahedra_vertex_extract DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_corner0(in_corner[0]), .in_corner1(in_corner[1]),
    .in_corner2(in_corner[2]), .in_corner3(in_corner[3]),
    .in_corner4(in_corner[4]), .in_corner5(in_corner[5]),
    .in_corner6(in_corner[6]), .in_corner7(in_corner[7]),
    .in_cube_x(in_cube_x), .in_cube_y(in_cube_y), .in_cube_z(in_cube_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_vert_x(out_vert_x), .out_vert_y(out_vert_y), .out_vert_z(out_vert_z),
    .out_last_vertex(out_last_vertex),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_iso_threshold(cfg_iso_threshold)
  );

  // one axis of a vertex: low end position plus fraction toward the high end
  function automatic logic [15:0] place_axis(logic [7:0] org, bit off_lo, bit off_hi,
                                             int frac);
    int pos;
    pos = ((int'(org) + int'(off_lo)) << 8) + (int'(off_hi) - int'(off_lo)) * frac;
    if (pos < 0) pos = 0;
    if (pos > int'(COORD_LIM)) pos = int'(COORD_LIM);
    return 16'(pos);
  endfunction

  // walk every edge of every tetrahedron and queue the vertex of every crossing
  task automatic predict_cube_vertices(logic [7:0] val [8], logic [7:0] ox,
                                       logic [7:0] oy, logic [7:0] oz);
    int count;
    logic [2:0] ca, cb, lo, hi;
    int frac;
    vertex_t v;
    count = 0;
    for (int t = 0; t < 6; t++)
      for (int e = 0; e < 6; e++) begin
        ca = TET[t][EA[e]];
        cb = TET[t][EB[e]];
        if ((val[ca] < iso_model) == (val[cb] < iso_model)) continue;
        if (val[ca] > val[cb]) begin
          lo = cb; hi = ca;
        end else begin
          lo = ca; hi = cb;
        end
        frac = ((int'(iso_model) - int'(val[lo])) << 8) / (int'(val[hi]) - int'(val[lo]));
        v.x = place_axis(ox, lo[0], hi[0], frac);
        v.y = place_axis(oy, lo[1], hi[1], frac);
        v.z = place_axis(oz, lo[2], hi[2], frac);
        v.last = 1'b0;
        pending_vertices.push_back(v);
        count++;
      end
    if (count > 0) pending_vertices[$].last = 1'b1;
  endtask

  // send one cube transaction after a random gap; valid stays up for back to back
  task automatic send_cube(logic [7:0] val [8], logic [7:0] ox, logic [7:0] oy,
                           logic [7:0] oz);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    for (int i = 0; i < 8; i++) in_corner[i] <= val[i];
    in_cube_x <= ox;
    in_cube_y <= oy;
    in_cube_z <= oz;
    in_valid <= 1'b1;
    predict_cube_vertices(val, ox, oy, oz);
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid, wait for every expected vertex, then let the back end settle
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // threshold write, only while idle
  task automatic write_threshold(logic [7:0] thr);
    drain_outputs();
    cfg_iso_threshold <= thr;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    iso_model = thr;
  endtask

  task automatic send_uniform(logic [7:0] a, logic [7:0] b, logic [7:0] ox,
                              logic [7:0] oy, logic [7:0] oz);
    logic [7:0] val [8];
    val[0] = a;
    for (int i = 1; i < 8; i++) val[i] = b;
    send_cube(val, ox, oy, oz);
  endtask

  // random cube; mostly near the threshold so crossings are common
  task automatic send_random_cube();
    logic [7:0] val [8];
    logic [7:0] o [3];
    int lo_v, hi_v;
    lo_v = (iso_model > 40) ? iso_model - 40 : 0;
    hi_v = (iso_model < 215) ? iso_model + 40 : 255;
    for (int i = 0; i < 8; i++)
      val[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(lo_v, hi_v));
    for (int a = 0; a < 3; a++)
      o[a] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(250, 255))
                                         : 8'($urandom_range(0, 255));
    send_cube(val, o[0], o[1], o[2]);
  endtask

  // directed: extremes, single corner crossings, saturation at grid edge
  task automatic test_directed();
    logic [7:0] val [8];
    send_uniform(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);        // all below, no crossing
    send_uniform(8'd255, 8'd255, 8'd1, 8'd2, 8'd3);    // all above, no crossing
    send_uniform(8'd0, 8'd255, 8'd0, 8'd0, 8'd0);      // origin corner alone inside
    send_uniform(8'd255, 8'd0, 8'd254, 8'd254, 8'd254);
    send_uniform(8'd24, 8'd25, 8'd255, 8'd255, 8'd255); // origin at grid edge
    for (int c = 1; c < 8; c++) begin
      for (int i = 0; i < 8; i++) val[i] = 8'd200;
      val[c] = 8'd3;
      send_cube(val, 8'(c * 36), 8'(255 - c), 8'(c));
    end
    for (int i = 0; i < 8; i++) val[i] = (i % 2) ? 8'd255 : 8'd0; // many crossings
    send_cube(val, 8'd170, 8'd85, 8'd255);
    for (int i = 0; i < 8; i++) val[i] = 8'(1 << i);
    send_cube(val, 8'd85, 8'd170, 8'd0);
  endtask

  task automatic test_threshold_extremes();
    write_threshold(8'd0);                              // nothing can be below
    send_uniform(8'd0, 8'd255, 8'd5, 8'd5, 8'd5);
    write_threshold(8'd255);
    send_uniform(8'd254, 8'd255, 8'd7, 8'd8, 8'd9);
    send_uniform(8'd0, 8'd255, 8'd255, 8'd0, 8'd255);
    write_threshold(8'd1);
    send_uniform(8'd0, 8'd1, 8'd10, 8'd20, 8'd30);
    send_uniform(8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
  endtask

  task automatic test_random(int n_cubes);
    write_threshold(8'($urandom_range(1, 254)));
    for (int i = 0; i < n_cubes; i++) begin
      if (i % 80 == 40) begin
        stall_always_off = ~stall_always_off;
        write_threshold(8'($urandom));
      end
      send_random_cube();
    end
  endtask

  // output stall drawn per vertex, with stretches of none
  initial begin
    int wait_n;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        wait_n = stall_always_off ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 2) == 0) wait_n = 0;
        if (wait_n != 0) begin
          out_stall <= 1'b1;
          repeat (wait_n - 1) @(posedge clk);
          @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // vertex checker
  always @(posedge clk) begin
    vertex_t exp_v;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_vertices.size() == 0) begin
        $error("unexpected vertex x=%0d y=%0d z=%0d", out_vert_x, out_vert_y, out_vert_z);
        failures++;
      end else begin
        exp_v = pending_vertices.pop_front();
        if (out_vert_x !== exp_v.x) begin
          $error("vert_x expected %0d actual %0d", exp_v.x, out_vert_x); failures++;
        end
        if (out_vert_y !== exp_v.y) begin
          $error("vert_y expected %0d actual %0d", exp_v.y, out_vert_y); failures++;
        end
        if (out_vert_z !== exp_v.z) begin
          $error("vert_z expected %0d actual %0d", exp_v.z, out_vert_z); failures++;
        end
        if (out_last_vertex !== exp_v.last) begin
          $error("last_vertex expected %0d actual %0d", exp_v.last, out_last_vertex);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_marching_tetrahedra_vertex_extract: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_threshold_extremes();
    test_random(300);
    drain_outputs();
    if (failures == 0 && pending_vertices.size() == 0)
      $display("tb_marching_tetrahedra_vertex_extract: PASS");
    else
      $display("tb_marching_tetrahedra_vertex_extract: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
src/mte_pkg.sv
src/mte_front.sv
src/mte_queue.sv
src/mte_back.sv
src/marching_tetrahedra_vertex_extract.sv
tb/tb_marching_tetrahedra_vertex_extract.sv
